@@ sv/gedlt_pkg.sv @@
// Shared types and constants for the GEDCOM line tokenizer.
// Used by gedlt_parse and gedcom_line_tokenizer; depends on nothing.
package gedlt_pkg;

  localparam int unsigned MAX_LINE_DEF = 512;
  localparam int unsigned POS_W        = 11;
  localparam int unsigned OFF_W        = 10;
  localparam int unsigned LEVEL_W      = 16;
  localparam int unsigned LINE_NUM_W   = 32;

  localparam logic [7:0] CHAR_AT   = 8'h40;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_SP   = 8'h20;
  localparam logic [7:0] CHAR_TAB  = 8'h09;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_CR   = 8'h0D;

  localparam logic [POS_W-1:0]   POS_MAX   = '1;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

  // Result status codes
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_LONG   = 3'd1;
  localparam logic [2:0] ST_NOLEV  = 3'd2;
  localparam logic [2:0] ST_INC    = 3'd3;
  localparam logic [2:0] ST_BLANKX = 3'd4;
  localparam logic [2:0] ST_NOWS   = 3'd5;

  // Parser phase within a line; PH_LEAD must stay zero (line start)
  typedef enum logic [3:0] {
    PH_LEAD   = 4'd0,
    PH_LEVEL  = 4'd1,
    PH_GAP1   = 4'd2,
    PH_XFIRST = 4'd3,
    PH_XBODY  = 4'd4,
    PH_XAFTER = 4'd5,
    PH_GAP2   = 4'd6,
    PH_TAG    = 4'd7,
    PH_VGAP   = 4'd8,
    PH_VALUE  = 4'd9,
    PH_ERR    = 4'd10
  } phase_e;

  // Per-line parse state, all zero at line start
  typedef struct packed {
    phase_e             phase;
    logic [POS_W-1:0]   char_pos;
    logic [LEVEL_W-1:0] level_acc;
    logic [OFF_W-1:0]   xref_begin;
    logic [OFF_W-1:0]   xref_length;
    logic [OFF_W-1:0]   tag_begin;
    logic [OFF_W-1:0]   tag_length;
    logic [OFF_W-1:0]   value_begin;
    logic [POS_W-1:0]   last_nonwhite;
    logic [2:0]         error_code;
    logic               saw_nonwhite;
  } line_t;

  // One result word
  typedef struct packed {
    logic [2:0]            status;
    logic [LEVEL_W-1:0]    level;
    logic                  has_xref;
    logic [OFF_W-1:0]      xref_start;
    logic [OFF_W-1:0]      xref_len;
    logic [OFF_W-1:0]      tag_start;
    logic [OFF_W-1:0]      tag_len;
    logic                  has_value;
    logic [OFF_W-1:0]      value_start;
    logic [OFF_W-1:0]      value_len;
    logic [LINE_NUM_W-1:0] line_number;
  } res_t;

endpackage

@@ sv/gedlt_parse.sv @@
// Per-character line parser: holds the line state and forms the result word
// at line end. Depends on gedlt_pkg.
module gedlt_parse #(
  parameter int unsigned MaxLine = gedlt_pkg::MAX_LINE_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             take_i,
  input  logic [7:0]       char_in_i,
  input  logic             line_end_i,
  output logic             res_valid_o,
  output gedlt_pkg::res_t  res_o
);

  localparam int unsigned LenW = gedlt_pkg::POS_W + 1;
  localparam int unsigned MulW = gedlt_pkg::LEVEL_W + 4;

  gedlt_pkg::line_t                        line_q, line_d;
  logic [gedlt_pkg::LINE_NUM_W-1:0]        lines_q, lines_next;
  logic                                    ws, dig, at, gap1;
  logic [3:0]                              dval;
  logic [gedlt_pkg::POS_W-1:0]             pos;
  logic [MulW-1:0]                         lev_mul;
  logic [LenW-1:0]                         len;
  logic [2:0]                              st;

  // Character classes
  assign ws  = (char_in_i == gedlt_pkg::CHAR_SP) || (char_in_i == gedlt_pkg::CHAR_TAB) ||
               (char_in_i == gedlt_pkg::CHAR_LF) || (char_in_i == gedlt_pkg::CHAR_CR);
  assign dig = (char_in_i >= gedlt_pkg::CHAR_ZERO) && (char_in_i <= gedlt_pkg::CHAR_NINE);
  assign at  = (char_in_i == gedlt_pkg::CHAR_AT);
  assign dval = 4'(char_in_i - gedlt_pkg::CHAR_ZERO);
  assign pos  = line_q.char_pos;

  // level * 10 + digit, by shift and add
  assign lev_mul = (MulW'(line_q.level_acc) << 3) + (MulW'(line_q.level_acc) << 1)
                   + MulW'(dval);

  // Next line state for this character
  always_comb begin
    line_d = line_q;
    gap1   = 1'b0;
    if (!ws) begin
      line_d.saw_nonwhite  = 1'b1;
      line_d.last_nonwhite = pos;
    end
    unique case (line_q.phase)
      gedlt_pkg::PH_LEAD: begin
        if (dig) begin
          line_d.level_acc = gedlt_pkg::LEVEL_W'(dval);
          line_d.phase     = gedlt_pkg::PH_LEVEL;
        end else if (!ws) begin
          line_d.error_code = gedlt_pkg::ST_NOLEV;
          line_d.phase      = gedlt_pkg::PH_ERR;
        end
      end
      gedlt_pkg::PH_LEVEL: begin
        if (dig) begin
          line_d.level_acc = (lev_mul > MulW'(gedlt_pkg::LEVEL_MAX)) ?
                             gedlt_pkg::LEVEL_MAX : lev_mul[gedlt_pkg::LEVEL_W-1:0];
        end else begin
          gap1 = 1'b1;
        end
      end
      gedlt_pkg::PH_GAP1: gap1 = 1'b1;
      gedlt_pkg::PH_XFIRST: begin
        if (at) begin
          line_d.error_code = gedlt_pkg::ST_BLANKX;
          line_d.phase      = gedlt_pkg::PH_ERR;
        end else begin
          line_d.phase = gedlt_pkg::PH_XBODY;
        end
      end
      gedlt_pkg::PH_XBODY: begin
        if (at) begin
          line_d.xref_length = pos[gedlt_pkg::OFF_W-1:0] - line_q.xref_begin + 1'b1;
          line_d.phase       = gedlt_pkg::PH_XAFTER;
        end
      end
      gedlt_pkg::PH_XAFTER: begin
        if (ws) begin
          line_d.phase = gedlt_pkg::PH_GAP2;
        end else begin
          line_d.error_code = gedlt_pkg::ST_NOWS;
          line_d.phase      = gedlt_pkg::PH_ERR;
        end
      end
      gedlt_pkg::PH_GAP2: begin
        if (!ws) begin
          line_d.tag_begin = pos[gedlt_pkg::OFF_W-1:0];
          line_d.phase     = gedlt_pkg::PH_TAG;
        end
      end
      gedlt_pkg::PH_TAG: begin
        if (ws) begin
          line_d.tag_length = pos[gedlt_pkg::OFF_W-1:0] - line_q.tag_begin;
          line_d.phase      = gedlt_pkg::PH_VGAP;
        end
      end
      gedlt_pkg::PH_VGAP: begin
        if (!ws) begin
          line_d.value_begin = pos[gedlt_pkg::OFF_W-1:0];
          line_d.phase       = gedlt_pkg::PH_VALUE;
        end
      end
      default: ;
    endcase
    // gap after the level; a non-digit ends the level and is handled here
    if (gap1) begin
      line_d.phase = gedlt_pkg::PH_GAP1;
      if (ws) begin
      end else if (at) begin
        line_d.xref_begin = pos[gedlt_pkg::OFF_W-1:0];
        line_d.phase      = gedlt_pkg::PH_XFIRST;
      end else begin
        line_d.tag_begin = pos[gedlt_pkg::OFF_W-1:0];
        line_d.phase     = gedlt_pkg::PH_TAG;
      end
    end
    line_d.char_pos = (pos != gedlt_pkg::POS_MAX) ? pos + 1'b1 : pos;
  end

  assign lines_next = lines_q + 1'b1;
  assign len        = LenW'(line_d.last_nonwhite) + 1'b1;

  // Result word from the state after this character
  always_comb begin
    res_o             = '0;
    res_o.level       = line_d.level_acc;
    res_o.line_number = lines_next;
    st                = gedlt_pkg::ST_OK;
    unique case (line_d.phase)
      gedlt_pkg::PH_TAG: begin
        res_o.tag_start = line_d.tag_begin;
        res_o.tag_len   = len[gedlt_pkg::OFF_W-1:0] - line_d.tag_begin;
      end
      gedlt_pkg::PH_VGAP: begin
        res_o.tag_start = line_d.tag_begin;
        res_o.tag_len   = line_d.tag_length;
      end
      gedlt_pkg::PH_VALUE: begin
        res_o.tag_start   = line_d.tag_begin;
        res_o.tag_len     = line_d.tag_length;
        res_o.has_value   = 1'b1;
        res_o.value_start = line_d.value_begin;
        res_o.value_len   = len[gedlt_pkg::OFF_W-1:0] - line_d.value_begin;
      end
      gedlt_pkg::PH_ERR: st = line_d.error_code;
      default:           st = gedlt_pkg::ST_INC;
    endcase
    if (st == gedlt_pkg::ST_OK && line_d.xref_length != '0) begin
      res_o.has_xref   = 1'b1;
      res_o.xref_start = line_d.xref_begin;
      res_o.xref_len   = line_d.xref_length;
    end
    // too long wins over every parse error
    if (len > LenW'(MaxLine)) st = gedlt_pkg::ST_LONG;
    if (st != gedlt_pkg::ST_OK) begin
      res_o.has_xref    = 1'b0;
      res_o.xref_start  = '0;
      res_o.xref_len    = '0;
      res_o.tag_start   = '0;
      res_o.tag_len     = '0;
      res_o.has_value   = 1'b0;
      res_o.value_start = '0;
      res_o.value_len   = '0;
      if (st == gedlt_pkg::ST_LONG || st == gedlt_pkg::ST_NOLEV) res_o.level = '0;
    end
    res_o.status = st;
  end

  assign res_valid_o = take_i && line_end_i && line_d.saw_nonwhite;

  // State registers; line state clears at every line end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q  <= '0;
      lines_q <= '0;
    end else if (take_i) begin
      if (line_end_i) begin
        line_q  <= '0;
        lines_q <= lines_next;
      end else begin
        line_q <= line_d;
      end
    end
  end

endmodule

@@ sv/gedcom_line_tokenizer.sv @@
// GEDCOM line tokenizer top level: parser plus output register and skid stage.
// Depends on gedlt_pkg and gedlt_parse.
//
// Usage: text enters one byte per word on the input channel (in_valid_i /
// in_ready_o), with line_end_i set on the last byte of each line. Lines of
// whitespace only are counted but give no word. Every other line gives one
// result word on the output channel (out_valid_o / out_ready_i) holding the
// status, level, field offsets and lengths, and the running line number.
// Results are registered into the output register, or into the skid entry if it is held.
// Throughput: one byte per cycle; the per-byte state update is a single
// register stage. The output side has a result register and one skid entry,
// so input stays ready while one result waits; in_ready_o drops only when
// both hold a word, and rises again the cycle after the receiver takes one.
// Reset (rst_ni low, asynchronous) returns to line start, zeroes the line
// count and empties both output entries.
module gedcom_line_tokenizer #(
  parameter int unsigned MaxLine = gedlt_pkg::MAX_LINE_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [7:0]                         char_in_i,
  input  logic                               line_end_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [2:0]                         status_o,
  output logic [gedlt_pkg::LEVEL_W-1:0]      level_o,
  output logic                               has_xref_o,
  output logic [gedlt_pkg::OFF_W-1:0]        xref_start_o,
  output logic [gedlt_pkg::OFF_W-1:0]        xref_len_o,
  output logic [gedlt_pkg::OFF_W-1:0]        tag_start_o,
  output logic [gedlt_pkg::OFF_W-1:0]        tag_len_o,
  output logic                               has_value_o,
  output logic [gedlt_pkg::OFF_W-1:0]        value_start_o,
  output logic [gedlt_pkg::OFF_W-1:0]        value_len_o,
  output logic [gedlt_pkg::LINE_NUM_W-1:0]   line_number_o
);

  logic            take, res_valid, out_free;
  gedlt_pkg::res_t res;
  logic            out_valid_q, skid_valid_q;
  gedlt_pkg::res_t out_q, skid_q;

  assign in_ready_o = !skid_valid_q;
  assign take       = in_valid_i && in_ready_o;

  gedlt_parse #(
    .MaxLine (MaxLine)
  ) u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .char_in_i   (char_in_i),
    .line_end_i  (line_end_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign out_free = !out_valid_q || out_ready_i;

  // Output register with one skid entry behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= res_valid;
      end else begin
        out_valid_q <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
        if (res_valid) skid_q <= res;
      end else if (res_valid) begin
        out_q <= res;
      end
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_q.status;
  assign level_o       = out_q.level;
  assign has_xref_o    = out_q.has_xref;
  assign xref_start_o  = out_q.xref_start;
  assign xref_len_o    = out_q.xref_len;
  assign tag_start_o   = out_q.tag_start;
  assign tag_len_o     = out_q.tag_len;
  assign has_value_o   = out_q.has_value;
  assign value_start_o = out_q.value_start;
  assign value_len_o   = out_q.value_len;
  assign line_number_o = out_q.line_number;

  // Skid entry is only ever filled behind a held output word
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid with output register empty");

  // A result is only formed from an accepted last byte of a line
  a_res_at_line_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (in_valid_i && in_ready_o && line_end_i))
    else $error("result formed without an accepted line end");

  // A stalled output word with a new result arriving fills the skid entry
  a_stall_fills_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i && res_valid) |=> skid_valid_q)
    else $error("result dropped while output stalled");

  // Status codes stay within the defined set
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o <= gedlt_pkg::ST_NOWS))
    else $error("undefined status code on output");

endmodule

@@ tb/gedcom_line_tokenizer_test.sv @@
// Self-checking testbench for gedcom_line_tokenizer: feeds GEDCOM line text one
// character per word and checks every result word against its own line parser.
// Depends on gedlt_pkg and the gedcom_line_tokenizer RTL; needs no files.
`timescale 1ns / 1ps

module gedcom_line_tokenizer_test;

  typedef logic [7:0] text_t[$];

  typedef enum logic [1:0] {
    KIND_CHAR,
    KIND_SYNC,
    KIND_HOLD
  } step_kind_e;

  // One entry of the sender's schedule: a character, or a pause marker
  typedef struct {
    step_kind_e  kind;
    logic [7:0]  ch;
    logic        last;
    int unsigned gap;
  } step_t;

  // Character budget for the whole run, and the size of the over-limit line
  localparam int unsigned ITEMS      = 650;
  localparam int unsigned LONG_CHARS = gedlt_pkg::MAX_LINE_DEF + 2;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [7:0] char_in_i = 8'h00;
  logic line_end_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [2:0] status_o;
  logic [gedlt_pkg::LEVEL_W-1:0] level_o;
  logic has_xref_o;
  logic [gedlt_pkg::OFF_W-1:0] xref_start_o;
  logic [gedlt_pkg::OFF_W-1:0] xref_len_o;
  logic [gedlt_pkg::OFF_W-1:0] tag_start_o;
  logic [gedlt_pkg::OFF_W-1:0] tag_len_o;
  logic has_value_o;
  logic [gedlt_pkg::OFF_W-1:0] value_start_o;
  logic [gedlt_pkg::OFF_W-1:0] value_len_o;
  logic [gedlt_pkg::LINE_NUM_W-1:0] line_number_o;

  // Parser state mirrored from the line being sent
  gedlt_pkg::line_t cur = '0;
  logic [gedlt_pkg::LINE_NUM_W-1:0] lines_read = '0;
  gedlt_pkg::res_t lines_due[$];

  step_t pending[$];
  bit send_idle = 1'b0;
  int unsigned send_wait = 0;
  int unsigned hold_asks = 0;
  int unsigned holds_done = 0;
  int unsigned hold_left = 0;
  int unsigned rx_wait = 0;
  int unsigned chars_queued = 0;
  int unsigned chars_sent = 0;
  int unsigned results_checked = 0;
  int unsigned faults = 0;
  int unsigned status_seen[8];

  always #10 clk_i = ~clk_i;

  gedcom_line_tokenizer u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .char_in_i    (char_in_i),
    .line_end_i   (line_end_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .level_o      (level_o),
    .has_xref_o   (has_xref_o),
    .xref_start_o (xref_start_o),
    .xref_len_o   (xref_len_o),
    .tag_start_o  (tag_start_o),
    .tag_len_o    (tag_len_o),
    .has_value_o  (has_value_o),
    .value_start_o(value_start_o),
    .value_len_o  (value_len_o),
    .line_number_o(line_number_o)
  );

  function automatic bit is_blank(logic [7:0] c);
    return c == gedlt_pkg::CHAR_SP || c == gedlt_pkg::CHAR_TAB ||
           c == gedlt_pkg::CHAR_LF || c == gedlt_pkg::CHAR_CR;
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= gedlt_pkg::CHAR_ZERO && c <= gedlt_pkg::CHAR_NINE;
  endfunction

  // Advance the parser by one character; at line end queue the expected word
  task automatic tokenize_char(input logic [7:0] c, input logic last);
    logic [gedlt_pkg::POS_W-1:0]   pos;
    logic                          blank;
    logic [gedlt_pkg::POS_W:0]     len;
    int unsigned                   lv;
    logic [2:0]                    st;
    logic [gedlt_pkg::LEVEL_W-1:0] lev;
    gedlt_pkg::res_t               r;
    pos   = cur.char_pos;
    blank = is_blank(c);
    if (!blank) begin
      cur.saw_nonwhite  = 1'b1;
      cur.last_nonwhite = pos;
    end
    case (cur.phase)
      gedlt_pkg::PH_LEAD: begin
        if (is_digit(c)) begin
          cur.level_acc = 16'(c - gedlt_pkg::CHAR_ZERO);
          cur.phase     = gedlt_pkg::PH_LEVEL;
        end else if (!blank) begin
          cur.error_code = gedlt_pkg::ST_NOLEV;
          cur.phase      = gedlt_pkg::PH_ERR;
        end
      end
      gedlt_pkg::PH_LEVEL, gedlt_pkg::PH_GAP1: begin
        if (cur.phase == gedlt_pkg::PH_LEVEL && is_digit(c)) begin
          lv = 32'(cur.level_acc) * 10 + 32'(c - gedlt_pkg::CHAR_ZERO);
          cur.level_acc = (lv > 32'(gedlt_pkg::LEVEL_MAX)) ? gedlt_pkg::LEVEL_MAX : 16'(lv);
        end else begin
          // a non-digit ends the level and is handled as gap text
          cur.phase = gedlt_pkg::PH_GAP1;
          if (!blank) begin
            if (c == gedlt_pkg::CHAR_AT) begin
              cur.xref_begin = pos[gedlt_pkg::OFF_W-1:0];
              cur.phase      = gedlt_pkg::PH_XFIRST;
            end else begin
              cur.tag_begin = pos[gedlt_pkg::OFF_W-1:0];
              cur.phase     = gedlt_pkg::PH_TAG;
            end
          end
        end
      end
      gedlt_pkg::PH_XFIRST: begin
        if (c == gedlt_pkg::CHAR_AT) begin
          cur.error_code = gedlt_pkg::ST_BLANKX;
          cur.phase      = gedlt_pkg::PH_ERR;
        end else begin
          cur.phase = gedlt_pkg::PH_XBODY;
        end
      end
      gedlt_pkg::PH_XBODY: begin
        if (c == gedlt_pkg::CHAR_AT) begin
          cur.xref_length = gedlt_pkg::OFF_W'(pos - cur.xref_begin + 1);
          cur.phase       = gedlt_pkg::PH_XAFTER;
        end
      end
      gedlt_pkg::PH_XAFTER: begin
        if (blank) begin
          cur.phase = gedlt_pkg::PH_GAP2;
        end else begin
          cur.error_code = gedlt_pkg::ST_NOWS;
          cur.phase      = gedlt_pkg::PH_ERR;
        end
      end
      gedlt_pkg::PH_GAP2: begin
        if (!blank) begin
          cur.tag_begin = pos[gedlt_pkg::OFF_W-1:0];
          cur.phase     = gedlt_pkg::PH_TAG;
        end
      end
      gedlt_pkg::PH_TAG: begin
        if (blank) begin
          cur.tag_length = gedlt_pkg::OFF_W'(pos - cur.tag_begin);
          cur.phase      = gedlt_pkg::PH_VGAP;
        end
      end
      gedlt_pkg::PH_VGAP: begin
        if (!blank) begin
          cur.value_begin = pos[gedlt_pkg::OFF_W-1:0];
          cur.phase       = gedlt_pkg::PH_VALUE;
        end
      end
      default: ;
    endcase
    cur.char_pos = (pos < gedlt_pkg::POS_MAX) ? pos + 1'b1 : gedlt_pkg::POS_MAX;

    if (last) begin
      lines_read = lines_read + 1'b1;
      if (cur.saw_nonwhite) begin
        len = {1'b0, cur.last_nonwhite} + 1'b1;
        r = '0;
        r.level = cur.level_acc;
        r.line_number = lines_read;
        case (cur.phase)
          gedlt_pkg::PH_TAG: begin
            r.tag_start = cur.tag_begin;
            r.tag_len   = gedlt_pkg::OFF_W'(len - cur.tag_begin);
          end
          gedlt_pkg::PH_VGAP: begin
            r.tag_start = cur.tag_begin;
            r.tag_len   = cur.tag_length;
          end
          gedlt_pkg::PH_VALUE: begin
            r.tag_start   = cur.tag_begin;
            r.tag_len     = cur.tag_length;
            r.has_value   = 1'b1;
            r.value_start = cur.value_begin;
            r.value_len   = gedlt_pkg::OFF_W'(len - cur.value_begin);
          end
          gedlt_pkg::PH_ERR: r.status = cur.error_code;
          default:           r.status = gedlt_pkg::ST_INC;
        endcase
        if (r.status == gedlt_pkg::ST_OK && cur.xref_length != '0) begin
          r.has_xref   = 1'b1;
          r.xref_start = cur.xref_begin;
          r.xref_len   = cur.xref_length;
        end
        // stripped length over the limit beats any parse error
        if (len > gedlt_pkg::MAX_LINE_DEF) r.status = gedlt_pkg::ST_LONG;
        if (r.status != gedlt_pkg::ST_OK) begin
          st  = r.status;
          lev = (st == gedlt_pkg::ST_LONG || st == gedlt_pkg::ST_NOLEV) ? '0 : r.level;
          r   = '0;
          r.status      = st;
          r.level       = lev;
          r.line_number = lines_read;
        end
        lines_due.push_back(r);
      end
      cur = '0;
    end
  endtask

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got,
                                      logic [31:0] line_no);
    if (want !== got) begin
      if (faults < 10)
        $display("line %0d: %s expected 0x%0h, got 0x%0h", line_no, field, want, got);
      faults++;
    end
  endfunction

  function automatic logic [7:0] ws_char();
    case ($urandom_range(0, 3))
      0:       return gedlt_pkg::CHAR_SP;
      1:       return gedlt_pkg::CHAR_TAB;
      2:       return gedlt_pkg::CHAR_LF;
      default: return gedlt_pkg::CHAR_CR;
    endcase
  endfunction

  // Any byte that is neither whitespace nor an at sign
  function automatic logic [7:0] word_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (is_blank(c) || c == gedlt_pkg::CHAR_AT);
    return c;
  endfunction

  function automatic text_t from_str(string s);
    text_t t;
    t = {};
    foreach (s[i]) t.push_back(s[i]);
    return t;
  endfunction

  // Level, optional xref, tag, optional value, with random spacing
  function automatic text_t well_formed_line();
    text_t t;
    int unsigned n;
    t = {};
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
    repeat (n) t.push_back(ws_char());
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 2);
    repeat (n) t.push_back(8'(gedlt_pkg::CHAR_ZERO + $urandom_range(0, 9)));
    repeat ($urandom_range(0, 2)) t.push_back(ws_char());
    if ($urandom_range(0, 1) != 0) begin
      t.push_back(gedlt_pkg::CHAR_AT);
      repeat ($urandom_range(1, 4)) t.push_back(word_char());
      t.push_back(gedlt_pkg::CHAR_AT);
      repeat ($urandom_range(1, 2)) t.push_back(ws_char());
    end
    repeat ($urandom_range(1, 5)) t.push_back(word_char());
    if ($urandom_range(0, 2) != 0) begin
      repeat ($urandom_range(1, 2)) t.push_back(ws_char());
      repeat ($urandom_range(0, 8)) t.push_back(8'($urandom_range(0, 255)));
    end
    repeat ($urandom_range(0, 2)) t.push_back(ws_char());
    return t;
  endfunction

  // Long value line: body characters, ending non-white, then trailing whitespace
  function automatic text_t long_line(int unsigned body, int unsigned tail);
    text_t t;
    t = from_str("0 T ");
    while (t.size() < body) t.push_back(word_char());
    repeat (tail) t.push_back(ws_char());
    return t;
  endfunction

  task automatic queue_line(input text_t txt);
    foreach (txt[i])
      pending.push_back('{KIND_CHAR, txt[i], i == txt.size() - 1,
                          send_idle ? $urandom_range(0, 9) : 0});
    chars_queued += txt.size();
  endtask

  // Sender: offers one character word at a time, holding it until taken
  always @(posedge clk_i) begin : char_driver
    logic  offer;
    step_t head;
    if (rst_ni) begin
      offer = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        tokenize_char(char_in_i, line_end_i);
        chars_sent++;
        offer = 1'b0;
      end
      if (!offer && pending.size() != 0) begin
        head = pending[0];
        case (head.kind)
          KIND_SYNC: if (lines_due.size() == 0) void'(pending.pop_front());
          KIND_HOLD: begin
            hold_asks <= hold_asks + 1;
            void'(pending.pop_front());
          end
          default: begin
            if (send_wait < head.gap) begin
              send_wait++;
            end else begin
              void'(pending.pop_front());
              send_wait = 0;
              char_in_i  <= head.ch;
              line_end_i <= head.last;
              offer = 1'b1;
            end
          end
        endcase
      end
      in_valid_i <= offer;
    end
  end

  // Receiver: checks each result word and paces out_ready_i
  always @(posedge clk_i) begin : result_check
    logic rdy;
    gedlt_pkg::res_t want;
    if (rst_ni) begin
      rdy = out_ready_i;
      if (out_valid_o && out_ready_i) begin
        if (lines_due.size() == 0) begin
          if (faults < 10)
            $display("unexpected result word: status %0d, line number %0d",
                     status_o, line_number_o);
          faults++;
        end else begin
          want = lines_due.pop_front();
          check_field("status", want.status, status_o, want.line_number);
          check_field("level", want.level, level_o, want.line_number);
          check_field("has_xref", want.has_xref, has_xref_o, want.line_number);
          check_field("xref_start", want.xref_start, xref_start_o, want.line_number);
          check_field("xref_len", want.xref_len, xref_len_o, want.line_number);
          check_field("tag_start", want.tag_start, tag_start_o, want.line_number);
          check_field("tag_len", want.tag_len, tag_len_o, want.line_number);
          check_field("has_value", want.has_value, has_value_o, want.line_number);
          check_field("value_start", want.value_start, value_start_o, want.line_number);
          check_field("value_len", want.value_len, value_len_o, want.line_number);
          check_field("line_number", want.line_number, line_number_o, want.line_number);
          status_seen[want.status]++;
        end
        results_checked++;
        rdy = 1'b0;
        // idle in stretches: every third block of words goes without gaps
        rx_wait = ((results_checked / 32) % 3 != 0) ? $urandom_range(0, 9) : 0;
      end
      if (hold_asks != holds_done) begin
        holds_done = holds_done + 1;
        hold_left  = 120;
      end
      if (hold_left != 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (!rdy) begin
        if (rx_wait != 0) rx_wait--;
        else rdy = 1'b1;
      end
      out_ready_i <= rdy;
    end
  end

  // Stimulus: directed lines, a back-pressure burst, random lines, a long line
  initial begin : stimulus
    text_t t;
    int unsigned lines;
    int unsigned pick;
    int unsigned n;

    // directed: level run into a tag, blank, no level, open xref, empty xref,
    // xref without a following space, xref at line end, byte FF tag,
    // saturated level with a zero byte tag and stripped value
    send_idle = 1'b0;
    queue_line(from_str("0A"));
    queue_line(from_str(" "));
    queue_line(from_str("X"));
    queue_line(from_str("1@"));
    queue_line(from_str("1@@"));
    queue_line(from_str("1@a@b"));
    queue_line(from_str("1@a@"));
    t = from_str("1@a@ T");
    t[5] = 8'hFF;
    queue_line(t);
    t = from_str("99999 x v\t");
    t[6] = 8'h00;
    queue_line(t);
    pending.push_back('{KIND_SYNC, 8'h00, 1'b0, 0});

    // receiver holds off while short lines stream in back to back
    pending.push_back('{KIND_HOLD, 8'h00, 1'b0, 0});
    repeat (12) begin
      t = '{8'(gedlt_pkg::CHAR_ZERO + $urandom_range(0, 9)), gedlt_pkg::CHAR_SP, word_char()};
      queue_line(t);
    end

    // random lines until only the long line is left of the budget
    lines = 0;
    while (chars_queued + LONG_CHARS < ITEMS) begin
      if (lines % 8 == 0) send_idle = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        t = well_formed_line();
      end else if (pick < 80) begin
        // cut short or corrupt one byte of a good line
        t = well_formed_line();
        if ($urandom_range(0, 1) != 0) begin
          n = $urandom_range(1, t.size());
          while (t.size() > n) void'(t.pop_back());
        end else begin
          t[$urandom_range(0, t.size() - 1)] = 8'($urandom_range(0, 255));
        end
      end else if (pick < 90) begin
        t = {};
        repeat ($urandom_range(1, 12))
          case ($urandom_range(0, 3))
            0:       t.push_back(8'(gedlt_pkg::CHAR_ZERO + $urandom_range(0, 9)));
            1:       t.push_back(ws_char());
            2:       t.push_back(gedlt_pkg::CHAR_AT);
            default: t.push_back(8'($urandom_range(0, 255)));
          endcase
      end else begin
        t = {};
        repeat ($urandom_range(1, 3)) t.push_back(ws_char());
      end
      queue_line(t);
      lines++;
    end

    // stripped length one over the limit, with trailing whitespace
    pending.push_back('{KIND_SYNC, 8'h00, 1'b0, 0});
    send_idle = 1'b0;
    queue_line(long_line(gedlt_pkg::MAX_LINE_DEF + 1, 1));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending.size() != 0 || in_valid_i) @(posedge clk_i);
    while (lines_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("Covered %0d characters over %0d lines; %0d result words checked",
             chars_sent, lines_read, results_checked);
    $display("Statuses: ok %0d, long %0d, no level %0d, incomplete %0d, empty xref %0d, %s %0d",
             status_seen[gedlt_pkg::ST_OK], status_seen[gedlt_pkg::ST_LONG],
             status_seen[gedlt_pkg::ST_NOLEV], status_seen[gedlt_pkg::ST_INC],
             status_seen[gedlt_pkg::ST_BLANKX], "no space after xref",
             status_seen[gedlt_pkg::ST_NOWS]);
    if (faults == 0) begin
      $display("gedcom_line_tokenizer_test passed");
    end else begin
      $display("gedcom_line_tokenizer_test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10000000;
    $display("gedcom_line_tokenizer_test failed");
    $finish;
  end

endmodule

@@ files.f @@
sv/gedlt_pkg.sv
sv/gedlt_parse.sv
sv/gedcom_line_tokenizer.sv
tb/gedcom_line_tokenizer_test.sv
